// File: sv/cst_pkg.sv
`default_nettype none

package cst_pkg;

    typedef enum logic [1:0] {
        KIND_PLUS    = 2'd0,
        KIND_SEMI    = 2'd1,
        KIND_INT     = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    // up to two tokens are written per transaction, the second only with the first
    typedef struct packed {
        logic push_a;
        logic push_b;
    } push_t;

    localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// File: sv/cst_front.sv
`default_nettype none

module cst_front #(
    parameter  int OFFSET_BITS = 24,
    parameter  int LINE_BITS   = 20,
    parameter  int COLUMN_BITS = 16,
    localparam int TOK_W       = 3 + LINE_BITS + 2 * COLUMN_BITS + 3 * OFFSET_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output      logic             s_ready,
    input  wire logic [7:0]       s_ch,
    input  wire logic             s_end_of_text,
    input  wire logic             room,
    output      cst_pkg::push_t   push,
    output      logic [TOK_W-1:0] tok_a,
    output      logic [TOK_W-1:0] tok_b
);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_BSTAR  = 3'd4,
        MODE_INT    = 3'd5
    } mode_t;

    typedef struct packed {
        cst_pkg::kind_t         kind;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] line_start_offset;
        logic [COLUMN_BITS-1:0] end_column;
        logic [OFFSET_BITS-1:0] end_offset;
        logic                   run_last;
    } tok_t;

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg, cur_col_next;
    logic [OFFSET_BITS-1:0] cur_off_reg, cur_off_next;
    logic [OFFSET_BITS-1:0] cur_ls_reg, cur_ls_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] tok_col_reg, tok_col_next;
    logic [OFFSET_BITS-1:0] tok_off_reg, tok_off_next;
    logic [OFFSET_BITS-1:0] tok_ls_reg, tok_ls_next;

    logic           accept;
    logic           nl;
    logic           is_space;
    logic           is_digit;
    logic           scan;
    logic           pend;
    logic           scan_emit;
    logic           eot_emit;
    cst_pkg::kind_t pend_kind;
    cst_pkg::kind_t scan_kind;
    cst_pkg::kind_t eot_kind;
    tok_t           t_pend, t_scan, t_eot, t_a, t_b;

    assign s_ready = room;
    assign accept  = s_valid && room;

    always_comb begin
        nl       = (s_ch == CH_NL);
        is_space = s_ch inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
        is_digit = s_ch inside {[8'h30:8'h39]};

        // one saturating position step per character
        cur_off_next  = (&cur_off_reg) ? cur_off_reg : cur_off_reg + OFFSET_BITS'(1);
        cur_line_next = cur_line_reg;
        cur_ls_next   = cur_ls_reg;
        if (nl) begin
            if (!(&cur_line_reg)) begin
                cur_line_next = cur_line_reg + LINE_BITS'(1);
            end
            cur_col_next = COLUMN_BITS'(1);
            cur_ls_next  = cur_off_next;
        end else begin
            cur_col_next = (&cur_col_reg) ? cur_col_reg : cur_col_reg + COLUMN_BITS'(1);
        end

        mode_next    = mode_reg;
        scan         = 1'b0;
        pend         = 1'b0;
        pend_kind    = cst_pkg::KIND_INVALID;
        case (mode_reg)
            MODE_SLASH: begin
                if (s_ch == CH_SLASH) begin
                    mode_next = MODE_LINE;
                end else if (s_ch == CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end else begin
                    pend = 1'b1;
                    scan = 1'b1;
                end
            end
            MODE_INT: begin
                if (!is_digit) begin
                    pend      = 1'b1;
                    pend_kind = cst_pkg::KIND_INT;
                    scan      = 1'b1;
                end
            end
            MODE_LINE: begin
                if (nl) begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                if (s_ch == CH_STAR) begin
                    mode_next = MODE_BSTAR;
                end
            end
            MODE_BSTAR: begin
                if (s_ch == CH_SLASH) begin
                    mode_next = MODE_NORMAL;
                end else if (s_ch != CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end
            end
            default: begin
                scan = 1'b1;
            end
        endcase

        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_off_next  = tok_off_reg;
        tok_ls_next   = tok_ls_reg;
        scan_emit     = 1'b0;
        scan_kind     = cst_pkg::KIND_INVALID;
        if (scan) begin
            mode_next = MODE_NORMAL;
            if (!is_space) begin
                tok_line_next = cur_line_reg;
                tok_col_next  = cur_col_reg;
                tok_off_next  = cur_off_reg;
                tok_ls_next   = cur_ls_reg;
                if (s_ch == CH_SLASH) begin
                    mode_next = MODE_SLASH;
                end else if (is_digit) begin
                    mode_next = MODE_INT;
                end else begin
                    scan_emit = 1'b1;
                    if (s_ch == CH_PLUS) begin
                        scan_kind = cst_pkg::KIND_PLUS;
                    end else if (s_ch == CH_SEMI) begin
                        scan_kind = cst_pkg::KIND_SEMI;
                    end
                end
            end
        end

        // end of text flushes a pending integer or slash
        eot_emit = s_end_of_text && (mode_next == MODE_INT || mode_next == MODE_SLASH);
        eot_kind = (mode_next == MODE_INT) ? cst_pkg::KIND_INT : cst_pkg::KIND_INVALID;

        t_pend = '{kind: pend_kind, start_line: tok_line_reg, start_column: tok_col_reg,
                   start_offset: tok_off_reg, line_start_offset: tok_ls_reg,
                   end_column: cur_col_reg, end_offset: cur_off_reg, run_last: 1'b0};
        t_scan = '{kind: scan_kind, start_line: cur_line_reg, start_column: cur_col_reg,
                   start_offset: cur_off_reg, line_start_offset: cur_ls_reg,
                   end_column: cur_col_next, end_offset: cur_off_next, run_last: 1'b0};
        t_eot  = '{kind: eot_kind, start_line: tok_line_next, start_column: tok_col_next,
                   start_offset: tok_off_next, line_start_offset: tok_ls_next,
                   end_column: cur_col_next, end_offset: cur_off_next, run_last: 1'b0};

        push.push_a = accept && (pend || scan_emit || eot_emit);
        push.push_b = accept && pend && (scan_emit || eot_emit);
        t_b          = scan_emit ? t_scan : t_eot;
        t_b.run_last = 1'b1;
        t_a          = pend ? t_pend : t_b;
        t_a.run_last = !(pend && (scan_emit || eot_emit));
        tok_a        = t_a;
        tok_b        = t_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_end_of_text)) begin
            mode_reg     <= MODE_NORMAL;
            cur_line_reg <= LINE_BITS'(1);
            cur_col_reg  <= COLUMN_BITS'(1);
            cur_off_reg  <= '0;
            cur_ls_reg   <= '0;
            tok_line_reg <= LINE_BITS'(1);
            tok_col_reg  <= COLUMN_BITS'(1);
            tok_off_reg  <= '0;
            tok_ls_reg   <= '0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            cur_off_reg  <= cur_off_next;
            cur_ls_reg   <= cur_ls_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            tok_off_reg  <= tok_off_next;
            tok_ls_reg   <= tok_ls_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/cst_queue.sv
`default_nettype none

module cst_queue #(
    parameter int TOK_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cst_pkg::push_t   push,
    input  wire logic [TOK_W-1:0] tok_a,
    input  wire logic [TOK_W-1:0] tok_b,
    output      logic             room,
    output      logic             head_valid,
    output      logic [TOK_W-1:0] head_tok,
    input  wire logic             pop
);

    localparam int PTR_W = $clog2(cst_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cst_pkg::QUEUE_DEPTH + 1);

    logic [TOK_W-1:0] entry_reg [cst_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       n_push;
    logic             do_pop;

    always_comb begin
        n_push      = {1'b0, push.push_a} + {1'b0, push.push_b};
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(do_pop);
    end

    // room for the worst case of two tokens from one transaction
    assign room       = (count_reg <= CNT_W'(cst_pkg::QUEUE_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head_tok   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push_a) begin
            entry_reg[wr_ptr_reg] <= tok_a;
        end
        if (push.push_b) begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= tok_b;
        end
    end

endmodule

`default_nettype wire

// File: sv/cst_back.sv
`default_nettype none

module cst_back #(
    parameter  int OFFSET_BITS = 24,
    parameter  int LINE_BITS   = 20,
    parameter  int COLUMN_BITS = 16,
    localparam int TOK_W       = 3 + LINE_BITS + 2 * COLUMN_BITS + 3 * OFFSET_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   head_valid,
    input  wire logic [TOK_W-1:0]       head_tok,
    output      logic                   pop,
    output      logic                   m_valid,
    input  wire logic                   m_ready,
    output      logic [1:0]             m_token_kind,
    output      logic [LINE_BITS-1:0]   m_start_line,
    output      logic [COLUMN_BITS-1:0] m_start_column,
    output      logic [OFFSET_BITS-1:0] m_start_offset,
    output      logic [OFFSET_BITS-1:0] m_line_start_offset,
    output      logic [COLUMN_BITS-1:0] m_end_column,
    output      logic [OFFSET_BITS-1:0] m_end_offset,
    output      logic                   m_run_last
);

    typedef struct packed {
        cst_pkg::kind_t         kind;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] line_start_offset;
        logic [COLUMN_BITS-1:0] end_column;
        logic [OFFSET_BITS-1:0] end_offset;
        logic                   run_last;
    } tok_t;

    logic valid_reg;
    tok_t out_reg;

    // refill the output register whenever it is empty or being taken
    assign pop = head_valid && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= tok_t'(head_tok);
        end
    end

    assign m_valid             = valid_reg;
    assign m_token_kind        = out_reg.kind;
    assign m_start_line        = out_reg.start_line;
    assign m_start_column      = out_reg.start_column;
    assign m_start_offset      = out_reg.start_offset;
    assign m_line_start_offset = out_reg.line_start_offset;
    assign m_end_column        = out_reg.end_column;
    assign m_end_offset        = out_reg.end_offset;
    assign m_run_last          = out_reg.run_last;

endmodule

`default_nettype wire

// File: sv/char_stream_tokenizer.sv
// a token is queued, then registered at the output; one character is taken per cycle while
// s_ready is high, and tokens leave one per cycle through a four-entry queue while m_ready
// is high; a character that closes an integer or slash adds two entries if it is itself a
// one-character token or starts an integer or slash at end of text; the input stalls while
// fewer than two queue entries are free; reset: synchronous active-low aresetn empties the
// queue and returns to line 1, column 1, offset 0; a queued end of text resets the position
`default_nettype none

module char_stream_tokenizer #(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output      logic                   s_ready,
    input  wire logic [7:0]             s_ch,
    input  wire logic                   s_end_of_text,
    output      logic                   m_valid,
    input  wire logic                   m_ready,
    output      logic [1:0]             m_token_kind,
    output      logic [LINE_BITS-1:0]   m_start_line,
    output      logic [COLUMN_BITS-1:0] m_start_column,
    output      logic [OFFSET_BITS-1:0] m_start_offset,
    output      logic [OFFSET_BITS-1:0] m_line_start_offset,
    output      logic [COLUMN_BITS-1:0] m_end_column,
    output      logic [OFFSET_BITS-1:0] m_end_offset,
    output      logic                   m_run_last
);

    localparam int TOK_W = 3 + LINE_BITS + 2 * COLUMN_BITS + 3 * OFFSET_BITS;

    cst_pkg::push_t   push;
    logic [TOK_W-1:0] tok_a;
    logic [TOK_W-1:0] tok_b;
    logic             room;
    logic             head_valid;
    logic [TOK_W-1:0] head_tok;
    logic             pop;

    cst_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_end_of_text (s_end_of_text),
        .room          (room),
        .push          (push),
        .tok_a         (tok_a),
        .tok_b         (tok_b)
    );

    cst_queue #(
        .TOK_W (TOK_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .tok_a      (tok_a),
        .tok_b      (tok_b),
        .room       (room),
        .head_valid (head_valid),
        .head_tok   (head_tok),
        .pop        (pop)
    );

    cst_back #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .head_valid          (head_valid),
        .head_tok            (head_tok),
        .pop                 (pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_token_kind        (m_token_kind),
        .m_start_line        (m_start_line),
        .m_start_column      (m_start_column),
        .m_start_offset      (m_start_offset),
        .m_line_start_offset (m_line_start_offset),
        .m_end_column        (m_end_column),
        .m_end_offset        (m_end_offset),
        .m_run_last          (m_run_last)
    );

endmodule

`default_nettype wire

// File: sv/cst_checker.sv
`default_nettype none

module cst_checker #(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [1:0]             m_token_kind,
    input wire logic [LINE_BITS-1:0]   m_start_line,
    input wire logic [COLUMN_BITS-1:0] m_start_column,
    input wire logic [OFFSET_BITS-1:0] m_start_offset,
    input wire logic [OFFSET_BITS-1:0] m_line_start_offset,
    input wire logic [COLUMN_BITS-1:0] m_end_column,
    input wire logic [OFFSET_BITS-1:0] m_end_offset,
    input wire logic                   m_run_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind) && $stable(m_start_offset)
            && $stable(m_end_offset) && $stable(m_run_last))
        else $error("result changed while stalled");

    a_positions_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_start_line != '0 && m_start_column != '0 && m_end_column != '0)
        else $error("line or column of zero");

    a_offset_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_end_offset >= m_start_offset && m_start_offset >= m_line_start_offset)
        else $error("token offsets out of order");

    // plus, semicolon and invalid tokens span a single character
    a_single_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != cst_pkg::KIND_INT && !(&m_start_offset)
            |-> m_end_offset == m_start_offset + OFFSET_BITS'(1))
        else $error("single-character token has wrong length");

endmodule

bind char_stream_tokenizer cst_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
) u_cst_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_token_kind        (m_token_kind),
    .m_start_line        (m_start_line),
    .m_start_column      (m_start_column),
    .m_start_offset      (m_start_offset),
    .m_line_start_offset (m_line_start_offset),
    .m_end_column        (m_end_column),
    .m_end_offset        (m_end_offset),
    .m_run_last          (m_run_last)
);

`default_nettype wire
